@@ sv/btpa_pkg.sv @@
`default_nettype none
package btpa_pkg;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] ADDR_IDX   = 2'd0;
  localparam logic [1:0] ADDR_LEFT  = 2'd1;
  localparam logic [1:0] ADDR_RIGHT = 2'd2;
  localparam logic [1:0] ADDR_SWEEP = 2'd3;

  localparam logic [1:0] WR_ZERO  = 2'd0;
  localparam logic [1:0] WR_NS    = 2'd1;
  localparam logic [1:0] WR_MERGE = 2'd2;
  localparam logic [1:0] WR_SWEEP = 2'd3;

  typedef struct packed {
    logic       ld_item;
    logic       ld_init;
    logic       rd_en;
    logic [1:0] addr_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       lat_lv;
    logic       pick;
    logic       to_parent;
    logic       set_root;
    logic       set_leaf;
    logic       out_ld;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       alloc_bad;
    logic       free_bad;
    logic       root_short;
    logic       at_want;
    logic       rd_zero;
    logic       idx_zero;
    logic       ns_ok;
    logic       sweep_last;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ sv/buddy_tree_page_allocator_core.sv @@
`default_nettype none
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    mode_i, request_pages_i, block_offset_i
// out       output     out_valid_o / out_stall_i  status_o, alloc_offset_o, free_page_count_o
// cfg       input      pool_pages_we_i            pool_pages_i
//
// One item at a time; the tree lives in a single-port RAM, one access a cycle.
// Alloc: checks the root, walks down the tree one level at a time, then updates each level up.
// Free: searches up from the leaf for the zeroed node, then coalesces each level up.
// After reset the tree is rebuilt by a sweep over all nodes; in_stall_o is high meanwhile.
// A finished beat waits in the output register; the next item is taken meanwhile.
module buddy_tree_page_allocator_core #(
  parameter int MAX_PAGES = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pool_pages_we_i,
  input  wire logic [10:0] pool_pages_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [10:0] request_pages_i,
  input  wire logic [9:0]  block_offset_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [9:0]       alloc_offset_o,
  output logic [10:0]      free_page_count_o
);

  btpa_pkg::dp_cmd_t cmd;
  btpa_pkg::dp_sts_t sts;

  btpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  btpa_dp #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (pool_pages_we_i),
    .cfg_data_i        (pool_pages_i),
    .mode_i            (mode_i),
    .req_i             (request_pages_i),
    .boff_i            (block_offset_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .status_o          (status_o),
    .alloc_offset_o    (alloc_offset_o),
    .free_page_count_o (free_page_count_o)
  );

endmodule
`default_nettype wire

@@ sv/btpa_dp.sv @@
`default_nettype none
module btpa_dp #(
  parameter int MAX_PAGES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [10:0]        cfg_data_i,
  input  wire logic [1:0]         mode_i,
  input  wire logic [10:0]        req_i,
  input  wire logic [9:0]         boff_i,
  input  wire btpa_pkg::dp_cmd_t  cmd_i,
  output btpa_pkg::dp_sts_t       sts_o,
  output logic [1:0]              status_o,
  output logic [9:0]              alloc_offset_o,
  output logic [10:0]             free_page_count_o
);

  localparam int NW  = $clog2(MAX_PAGES) + 1;
  localparam int TN  = 2 * MAX_PAGES - 1;
  localparam int IW  = $clog2(TN);
  localparam int CW  = (NW > 12) ? NW : 12;
  localparam int LW  = $clog2(CW);
  localparam int OW  = (IW + 1 > 10) ? IW + 1 : 10;
  localparam int LI  = $clog2(IW + 1);
  localparam logic [CW-1:0] MaxC = CW'(MAX_PAGES);

  function automatic logic [LW-1:0] ceil_log2(input logic [10:0] x);
    logic [LW-1:0] r;
    logic          hit;
    r   = '0;
    hit = 1'b0;
    for (int i = 0; i < 12; i++) begin
      if (!hit && ((CW'(1) << i) >= CW'(x))) begin
        r   = LW'(i);
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  logic [10:0]   pool_q;
  logic [1:0]    mode_q;
  logic [CW-1:0] want_q;
  logic [LW-1:0] wantl_q;
  logic [9:0]    boff_q;
  logic [NW-1:0] act_q, free_q, lv_q, rd_q;
  logic [LW-1:0] actl_q, szl_q, nsl_q;
  logic [IW-1:0] idx_q, cnt_q;
  logic [9:0]    off_q;
  logic [1:0]    out_st_q;
  logic [9:0]    out_off_q;
  logic [NW-1:0] out_free_q;
  logic [NW-1:0] mem_q [TN];

  // pool rounding at init
  logic [CW-1:0] pmin;
  logic [LW-1:0] phb;
  always_comb begin
    pmin = (CW'(pool_q) > MaxC) ? MaxC : CW'(pool_q);
    phb  = '0;
    for (int i = 0; i < CW; i++) begin
      if (pmin[i]) phb = LW'(i);
    end
  end

  // node value for the sweep index
  logic [IW:0]   c1;
  logic [LI-1:0] lvl;
  logic [NW-1:0] sweep_val;
  always_comb begin
    c1  = (IW+1)'(cnt_q) + 1'b1;
    lvl = '0;
    for (int i = 0; i <= IW; i++) begin
      if (c1[i]) lvl = LI'(i);
    end
    sweep_val = (c1 < ((IW+1)'(act_q) << 1)) ? (act_q >> lvl) : '0;
  end

  logic [IW-1:0] left_idx, right_idx, parent_idx, leaf_idx, addr;
  assign left_idx   = {idx_q[IW-2:0], 1'b1};
  assign right_idx  = left_idx + 1'b1;
  assign parent_idx = IW'((idx_q - 1'b1) >> 1);
  assign leaf_idx   = IW'(boff_q) + IW'(act_q) - 1'b1;

  always_comb begin
    case (cmd_i.addr_sel)
      btpa_pkg::ADDR_LEFT:  addr = left_idx;
      btpa_pkg::ADDR_RIGHT: addr = right_idx;
      btpa_pkg::ADDR_SWEEP: addr = cnt_q;
      default:              addr = idx_q;
    endcase
  end

  logic [NW:0]   sum, nsv;
  logic [NW-1:0] mx, wdata;
  assign sum = (NW+1)'(lv_q) + (NW+1)'(rd_q);
  assign nsv = (NW+1)'(1) << nsl_q;
  assign mx  = (lv_q > rd_q) ? lv_q : rd_q;

  always_comb begin
    case (cmd_i.wr_sel)
      btpa_pkg::WR_ZERO: wdata = '0;
      btpa_pkg::WR_NS:   wdata = nsv[NW-1:0];
      btpa_pkg::WR_MERGE: begin
        wdata = (mode_q == btpa_pkg::MODE_FREE && sum == nsv) ? nsv[NW-1:0] : mx;
      end
      default:           wdata = sweep_val;
    endcase
  end

  logic lv_fit, rv_fit, go_right;
  assign lv_fit   = CW'(lv_q) >= want_q;
  assign rv_fit   = CW'(rd_q) >= want_q;
  assign go_right = lv_fit ? (rv_fit && (rd_q < lv_q)) : 1'b1;

  logic [OW-1:0] off_full;
  assign off_full = (OW'(idx_q) + 1'b1 << szl_q) - OW'(act_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem_q[addr] <= wdata;
    if (cmd_i.rd_en) rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= 11'd1024;
    end else if (cfg_we_i) begin
      pool_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      mode_q  <= mode_i;
      want_q  <= CW'(1) << ceil_log2(req_i);
      wantl_q <= ceil_log2(req_i);
      boff_q  <= boff_i;
      off_q   <= '0;
    end
    if (cmd_i.ld_init) begin
      act_q  <= (pmin == '0) ? '0 : NW'(CW'(1) << phb);
      free_q <= (pmin == '0) ? '0 : NW'(CW'(1) << phb);
      actl_q <= phb;
      cnt_q  <= '0;
    end else if (cmd_i.wr_en && cmd_i.wr_sel == btpa_pkg::WR_SWEEP) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.wr_en && cmd_i.wr_sel == btpa_pkg::WR_ZERO) begin
      free_q <= free_q - want_q[NW-1:0];
      off_q  <= off_full[9:0];
    end
    if (cmd_i.wr_en && cmd_i.wr_sel == btpa_pkg::WR_NS) begin
      free_q <= free_q + nsv[NW-1:0];
    end
    if (cmd_i.lat_lv) lv_q <= rd_q;
    if (cmd_i.set_root) begin
      idx_q <= '0;
      szl_q <= actl_q;
    end else if (cmd_i.set_leaf) begin
      idx_q <= leaf_idx;
      nsl_q <= '0;
    end else if (cmd_i.pick) begin
      idx_q <= go_right ? right_idx : left_idx;
      szl_q <= szl_q - 1'b1;
    end else if (cmd_i.to_parent) begin
      idx_q <= parent_idx;
      nsl_q <= nsl_q + 1'b1;
    end
    if (cmd_i.out_ld) begin
      out_st_q   <= cmd_i.out_status;
      out_off_q  <= (cmd_i.out_status == btpa_pkg::ST_OK) ? off_q : '0;
      out_free_q <= free_q;
    end
  end

  logic [CW-1:0] free_w;
  assign free_w            = CW'(out_free_q);
  assign status_o          = out_st_q;
  assign alloc_offset_o    = out_off_q;
  assign free_page_count_o = free_w[10:0];

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.alloc_bad  = (act_q == '0) || (want_q > CW'(act_q));
    sts_o.free_bad   = (act_q == '0) || (CW'(boff_q) >= CW'(act_q)) ||
                       (want_q > CW'(act_q)) || ((CW'(boff_q) & (want_q - 1'b1)) != '0);
    sts_o.root_short = CW'(rd_q) < want_q;
    sts_o.at_want    = szl_q == wantl_q;
    sts_o.rd_zero    = rd_q == '0;
    sts_o.idx_zero   = idx_q == '0;
    sts_o.ns_ok      = nsl_q == wantl_q;
    sts_o.sweep_last = cnt_q == IW'(TN - 1);
  end

endmodule
`default_nettype wire

@@ sv/btpa_ctrl.sv @@
`default_nettype none
module btpa_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire btpa_pkg::dp_sts_t  sts_i,
  output btpa_pkg::dp_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_SWEEP = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_AROOT = 4'd5;
  localparam logic [3:0] S_ACHK  = 4'd6;
  localparam logic [3:0] S_ARR   = 4'd7;
  localparam logic [3:0] S_APICK = 4'd8;
  localparam logic [3:0] S_FRD   = 4'd9;
  localparam logic [3:0] S_FCHK  = 4'd10;
  localparam logic [3:0] S_UP    = 4'd11;
  localparam logic [3:0] S_URL   = 4'd12;
  localparam logic [3:0] S_URR   = 4'd13;
  localparam logic [3:0] S_UW    = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] st_q, st_d;
  logic       emit_q, emit_d;
  logic       ovld_q, ovld_d;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    emit_d  = emit_q;
    cmd_o   = '0;
    ovld_d  = ovld_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          emit_d  = 1'b1;
          st_d    = btpa_pkg::ST_OK;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.mode)
          btpa_pkg::MODE_INIT: state_d = S_INIT;
          btpa_pkg::MODE_ALLOC: begin
            if (sts_i.alloc_bad) begin
              st_d    = btpa_pkg::ST_NOSPACE;
              state_d = S_DONE;
            end else begin
              cmd_o.set_root = 1'b1;
              state_d = S_ARD;
            end
          end
          btpa_pkg::MODE_FREE: begin
            if (sts_i.free_bad) begin
              st_d    = btpa_pkg::ST_INVALID;
              state_d = S_DONE;
            end else begin
              cmd_o.set_leaf = 1'b1;
              state_d = S_FRD;
            end
          end
          default: begin
            st_d    = btpa_pkg::ST_INVALID;
            state_d = S_DONE;
          end
        endcase
      end
      S_INIT: begin
        cmd_o.ld_init = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = btpa_pkg::WR_SWEEP;
        cmd_o.addr_sel = btpa_pkg::ADDR_SWEEP;
        if (sts_i.sweep_last) state_d = emit_q ? S_DONE : S_IDLE;
      end
      S_ARD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = btpa_pkg::ADDR_IDX;
        state_d = S_AROOT;
      end
      S_AROOT: begin
        if (sts_i.root_short) begin
          st_d    = btpa_pkg::ST_NOSPACE;
          state_d = S_DONE;
        end else begin
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts_i.at_want) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = btpa_pkg::WR_ZERO;
          cmd_o.addr_sel = btpa_pkg::ADDR_IDX;
          state_d = S_UP;
        end else begin
          cmd_o.rd_en    = 1'b1;
          cmd_o.addr_sel = btpa_pkg::ADDR_LEFT;
          state_d = S_ARR;
        end
      end
      S_ARR: begin
        cmd_o.lat_lv   = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = btpa_pkg::ADDR_RIGHT;
        state_d = S_APICK;
      end
      S_APICK: begin
        cmd_o.pick = 1'b1;
        state_d = S_ACHK;
      end
      S_FRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = btpa_pkg::ADDR_IDX;
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (!sts_i.rd_zero) begin
          if (sts_i.idx_zero) begin
            st_d    = btpa_pkg::ST_INVALID;
            state_d = S_DONE;
          end else begin
            cmd_o.to_parent = 1'b1;
            state_d = S_FRD;
          end
        end else if (!sts_i.ns_ok) begin
          st_d    = btpa_pkg::ST_INVALID;
          state_d = S_DONE;
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = btpa_pkg::WR_NS;
          cmd_o.addr_sel = btpa_pkg::ADDR_IDX;
          state_d = S_UP;
        end
      end
      S_UP: begin
        if (sts_i.idx_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.to_parent = 1'b1;
          state_d = S_URL;
        end
      end
      S_URL: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = btpa_pkg::ADDR_LEFT;
        state_d = S_URR;
      end
      S_URR: begin
        cmd_o.lat_lv   = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = btpa_pkg::ADDR_RIGHT;
        state_d = S_UW;
      end
      S_UW: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = btpa_pkg::WR_MERGE;
        cmd_o.addr_sel = btpa_pkg::ADDR_IDX;
        state_d = S_UP;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ovld_q || !out_stall_i) begin
          cmd_o.out_ld     = 1'b1;
          cmd_o.out_status = st_q;
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      st_q    <= btpa_pkg::ST_OK;
      emit_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      emit_q  <= emit_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule
`default_nettype wire

@@ test/tb_buddy_tree_page_allocator_core.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_buddy_tree_page_allocator_core;

  localparam int MAX_PG = 1024;
  localparam int NODES  = 2 * MAX_PG - 1;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] req;
    logic [9:0]  boff;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  offset;
    logic [10:0] free_cnt;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        pool_pages_we_i = 1'b0;
  logic [10:0] pool_pages_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = '0;
  logic [10:0] request_pages_i = '0;
  logic [9:0]  block_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  alloc_offset_o;
  logic [10:0] free_page_count_o;

  buddy_tree_page_allocator_core #(.MAX_PAGES(MAX_PG)) u_dut (
    .clk_i, .rst_ni, .pool_pages_we_i, .pool_pages_i, .in_valid_i, .in_stall_o,
    .mode_i, .request_pages_i, .block_offset_i, .out_valid_o, .out_stall_i,
    .status_o, .alloc_offset_o, .free_page_count_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // allocator shadow
  int unsigned lf_tree[NODES];
  int unsigned pool_reg, pool_size, shadow_free;
  // live allocations for well-formed frees
  int unsigned live_off[$], live_sz[$];

  op_t  pending_ops[$];
  res_t expected_res[$];
  int   mismatches = 0;
  int   beats_out = 0;
  int   send_idle_pct = 0, recv_idle_pct = 0;
  bit   hold_recv = 1'b0;
  bit   in_held = 1'b0;

  function automatic int unsigned pow2_up(int unsigned x);
    int unsigned r;
    r = 1;
    while (r < x) r <<= 1;
    return r;
  endfunction

  function automatic void rebuild_tree();
    int unsigned p, sz, cnt, idx;
    p = pool_reg > MAX_PG ? MAX_PG : pool_reg;
    if (p != 0) begin
      sz = 1;
      while (sz <= p / 2) sz <<= 1;
      p = sz;
    end
    pool_size = p;
    shadow_free = p;
    live_off.delete();
    live_sz.delete();
    foreach (lf_tree[i]) lf_tree[i] = 0;
    idx = 0;
    sz = p;
    cnt = 1;
    while (sz >= 1) begin
      for (int k = 0; k < cnt && idx < NODES; k++) lf_tree[idx++] = sz;
      sz >>= 1;
      cnt <<= 1;
    end
  endfunction

  function automatic res_t apply_op(op_t op);
    res_t r;
    int unsigned want, idx, sz, lv, rv, ns;
    r = '0;
    case (op.mode)
      btpa_pkg::MODE_INIT: rebuild_tree();
      btpa_pkg::MODE_ALLOC: begin
        want = pow2_up(op.req == 0 ? 1 : op.req);
        if (pool_size == 0 || want > pool_size || lf_tree[0] < want) begin
          r.status = btpa_pkg::ST_NOSPACE;
        end else begin
          idx = 0;
          sz = pool_size;
          while (sz != want) begin
            lv = lf_tree[2*idx+1];
            rv = lf_tree[2*idx+2];
            if (lv >= want) idx = (rv >= want && rv < lv) ? 2*idx+2 : 2*idx+1;
            else idx = 2*idx+2;
            sz >>= 1;
          end
          lf_tree[idx] = 0;
          r.offset = 10'((idx + 1) * sz - pool_size);
          live_off.push_back(32'(r.offset));
          live_sz.push_back(want);
          while (idx != 0) begin
            idx = (idx - 1) / 2;
            lv = lf_tree[2*idx+1];
            rv = lf_tree[2*idx+2];
            lf_tree[idx] = lv > rv ? lv : rv;
          end
          shadow_free -= want;
        end
      end
      btpa_pkg::MODE_FREE: begin
        sz = pow2_up(op.req == 0 ? 1 : op.req);
        r.status = btpa_pkg::ST_INVALID;
        if (!(pool_size == 0 || op.boff >= pool_size || sz > pool_size ||
              (op.boff & (sz - 1)) != 0)) begin
          idx = op.boff + pool_size - 1;
          ns = 1;
          while (lf_tree[idx] != 0 && idx != 0) begin
            idx = (idx - 1) / 2;
            ns <<= 1;
          end
          if (lf_tree[idx] == 0 && ns == sz) begin
            r.status = btpa_pkg::ST_OK;
            lf_tree[idx] = ns;
            shadow_free += ns;
            foreach (live_off[i])
              if (live_off[i] == op.boff && live_sz[i] == sz) begin
                live_off.delete(i);
                live_sz.delete(i);
                break;
              end
            while (idx != 0) begin
              idx = (idx - 1) / 2;
              ns <<= 1;
              lv = lf_tree[2*idx+1];
              rv = lf_tree[2*idx+2];
              lf_tree[idx] = (lv + rv == ns) ? ns : (lv > rv ? lv : rv);
            end
          end
        end
      end
      default: r.status = btpa_pkg::ST_INVALID;
    endcase
    r.free_cnt = 11'(shadow_free);
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_held) begin
        // hold the stalled beat
      end else if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i      <= 1'b1;
        mode_i          <= pending_ops[0].mode;
        request_pages_i <= pending_ops[0].req;
        block_offset_i  <= pending_ops[0].boff;
        void'(pending_ops.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= hold_recv || $urandom_range(99) < recv_idle_pct;
    end
  end

  // monitor: predict on input beat, compare on output beat
  always @(posedge clk_i) begin
    res_t got, exp_r;
    in_held <= rst_ni && in_valid_i && in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      expected_res.push_back(apply_op({mode_i, request_pages_i, block_offset_i}));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {status_o, alloc_offset_o, free_page_count_o};
      beats_out++;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        exp_r = expected_res.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp st=%0d off=%0d free=%0d got st=%0d off=%0d free=%0d",
                     beats_out, exp_r.status, exp_r.offset, exp_r.free_cnt,
                     got.status, got.offset, got.free_cnt);
        end
      end
    end
  end

  task automatic push_op(logic [1:0] m, int unsigned rq, int unsigned bo);
    op_t o;
    o.mode = m;
    o.req = rq[10:0];
    o.boff = bo[9:0];
    pending_ops.push_back(o);
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0);
    @(posedge clk_i);
    while (in_valid_i || expected_res.size() != 0) @(posedge clk_i);
    repeat (2 * MAX_PG + 100) @(posedge clk_i);
  endtask

  task automatic write_pool(int unsigned v);
    @(negedge clk_i);
    pool_pages_we_i <= 1'b1;
    pool_pages_i    <= v[10:0];
    @(negedge clk_i);
    pool_pages_we_i <= 1'b0;
    pool_reg = v;
    push_op(btpa_pkg::MODE_INIT, 0, 0);
  endtask

  task automatic random_ops(int n);
    int unsigned k, sz;
    repeat (n) begin
      k = $urandom_range(99);
      if (k < 45) begin
        // mostly small requests, few large
        sz = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(16);
        push_op(btpa_pkg::MODE_ALLOC, sz, $urandom);
        // predict later; track frees through a shadow list filled at acceptance
      end else if (k < 85 && live_off.size() != 0) begin
        sz = $urandom_range(live_off.size() - 1);
        push_op(btpa_pkg::MODE_FREE, live_sz[sz], live_off[sz]);
        live_off.delete(sz);
        live_sz.delete(sz);
      end else if (k < 97) begin
        push_op(btpa_pkg::MODE_FREE, $urandom_range(2047), $urandom);
      end else begin
        push_op($urandom_range(3) == 0 ? MODE_UNUSED : btpa_pkg::MODE_INIT,
                $urandom, $urandom);
      end
      wait (pending_ops.size() < 4);
    end
  endtask

  initial begin
    pool_reg = 1024;
    rebuild_tree();
    send_idle_pct = 14;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed
    push_op(btpa_pkg::MODE_ALLOC, 0, 0);
    push_op(btpa_pkg::MODE_ALLOC, 3, 0);
    push_op(btpa_pkg::MODE_ALLOC, 1, 0);
    push_op(btpa_pkg::MODE_ALLOC, 2047, 0);
    push_op(btpa_pkg::MODE_FREE, 1, 1);
    push_op(btpa_pkg::MODE_FREE, 4, 2);
    push_op(btpa_pkg::MODE_FREE, 2, 4);
    push_op(btpa_pkg::MODE_FREE, 1, 0);
    push_op(btpa_pkg::MODE_FREE, 1, 0);
    push_op(btpa_pkg::MODE_FREE, 1, 1023);
    push_op(MODE_UNUSED, 2047, 1023);
    push_op(btpa_pkg::MODE_ALLOC, 1024, 0);
    push_op(btpa_pkg::MODE_ALLOC, 1, 0);
    push_op(btpa_pkg::MODE_FREE, 1024, 0);
    push_op(btpa_pkg::MODE_FREE, 0, 0);
    push_op(btpa_pkg::MODE_INIT, 0, 0);
    drain();
    write_pool(0);
    push_op(btpa_pkg::MODE_ALLOC, 1, 0);
    push_op(btpa_pkg::MODE_FREE, 1, 0);
    drain();
    write_pool(2047);
    push_op(btpa_pkg::MODE_ALLOC, 512, 0);
    drain();

    live_off.delete();
    live_sz.delete();
    write_pool(1);
    random_ops(100);
    drain();
    live_off.delete();
    live_sz.delete();
    write_pool($urandom_range(2, 100));
    random_ops(300);
    // long receiver hold-off while items keep coming
    fork
      begin
        hold_recv = 1'b1;
        repeat (600) @(posedge clk_i);
        hold_recv = 1'b0;
      end
    join_none
    random_ops(20);
    drain();

    live_off.delete();
    live_sz.delete();
    send_idle_pct = 76;
    recv_idle_pct = 14;
    write_pool(1024);
    random_ops(500);
    drain();

    live_off.delete();
    live_sz.delete();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_pool($urandom_range(500, 1000));
    random_ops(550);
    drain();

    if (mismatches == 0 && expected_res.size() == 0)
      $display("** buddy_tree_page_allocator_core: PASSED **");
    else
      $display("** buddy_tree_page_allocator_core: FAILED **");
    $finish;
  end

  initial begin
    #200ms;
    $display("** buddy_tree_page_allocator_core: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

@@ sim.f @@
sv/btpa_pkg.sv
sv/btpa_dp.sv
sv/btpa_ctrl.sv
sv/buddy_tree_page_allocator_core.sv
test/tb_buddy_tree_page_allocator_core.sv
